### design/lrukc_pkg.sv
// Shared types and constants for the LRU keyed result cache.
package lrukc_pkg;

   localparam int KEY_W          = 32;
   localparam int PAYLOAD_W      = 32;
   localparam int COUNT_W        = 7;
   localparam int ENTRY_W        = KEY_W + PAYLOAD_W;
   localparam int CAPACITY_RESET = 60;

   typedef enum logic [1:0] {
      FUNC_LOOKUP = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_CLEAR  = 2'd2
   } lrukc_func_type;

   typedef struct packed {
      lrukc_func_type         func;
      logic [KEY_W-1:0]       key;
      logic [PAYLOAD_W-1:0]   payload;
      logic                   insert_ok;
   } lrukc_req_type;

   typedef struct packed {
      logic                   hit;
      logic [PAYLOAD_W-1:0]   payload_out;
      logic [COUNT_W-1:0]     fill_count;
   } lrukc_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_SHIFT_END,
      ST_WRITE,
      ST_DONE
   } lrukc_state_type;

endpackage

### design/lru_keyed_result_cache_core.sv
// Top level of the LRU keyed result cache: engine, entry RAM and result register.
//
//   channel | direction | handshake            | beat
//   req     | in        | req_valid/req_ready  | lrukc_req_type
//   rsp     | out       | rsp_valid/rsp_ready  | lrukc_rsp_type
//   csr     | in        | csr_valid/csr_ready  | capacity, 7 bits
//
// Entries are kept in the RAM in recency order, oldest at address 0.
// A lookup scans newest to oldest, one entry a cycle, then a hit shifts the younger
// entries down one a cycle and rewrites the tail. The single RAM read port makes
// the scan and the shift go one entry at a time.
// Reset empties the cache at once and sets capacity to 60 (or MAX_ENTRIES).
// A new beat is taken while the previous result waits in the output register.
module lru_keyed_result_cache_core #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  lrukc_pkg::lrukc_req_type          req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output lrukc_pkg::lrukc_rsp_type          rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lrukc_pkg::COUNT_W-1:0]     csr_data
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);

   logic                               res_valid;
   logic                               res_free;
   lrukc_pkg::lrukc_rsp_type           res_data;
   logic                               ram_wr_en;
   logic [IDX_W-1:0]                   ram_wr_addr;
   logic [lrukc_pkg::ENTRY_W-1:0]      ram_wr_data;
   logic [IDX_W-1:0]                   ram_rd_addr;
   logic [lrukc_pkg::ENTRY_W-1:0]      ram_rd_data;

   logic                               rsp_valid_ff, rsp_valid_in;
   lrukc_pkg::lrukc_rsp_type           rsp_data_ff, rsp_data_in;

   lrukc_engine #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .res_free    (res_free),
      .res_valid   (res_valid),
      .res_data    (res_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   lrukc_ram #(
      .WIDTH (lrukc_pkg::ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // output register frees when empty or drained this cycle
   assign res_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### design/lrukc_ram.sv
// Generic single write port, single read port RAM with registered read.
module lrukc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/lrukc_engine.sv
// Sequencer for the cache: newest-first scan, entry shift and tail write over one RAM.
module lrukc_engine #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  lrukc_pkg::lrukc_req_type             req_data,
   input  logic                                 csr_valid,
   input  logic [lrukc_pkg::COUNT_W-1:0]        csr_data,
   input  logic                                 res_free,
   output logic                                 res_valid,
   output lrukc_pkg::lrukc_rsp_type             res_data,
   output logic                                 ram_wr_en,
   output logic [$clog2(MAX_ENTRIES)-1:0]       ram_wr_addr,
   output logic [lrukc_pkg::ENTRY_W-1:0]        ram_wr_data,
   output logic [$clog2(MAX_ENTRIES)-1:0]       ram_rd_addr,
   input  logic [lrukc_pkg::ENTRY_W-1:0]        ram_rd_data
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CW    = $clog2(MAX_ENTRIES + 1);
   localparam int CAP_RESET = (lrukc_pkg::CAPACITY_RESET > MAX_ENTRIES) ?
                              MAX_ENTRIES : lrukc_pkg::CAPACITY_RESET;

   lrukc_pkg::lrukc_state_type            state_ff, state_in;
   logic [lrukc_pkg::KEY_W-1:0]           key_ff, key_in;
   logic [lrukc_pkg::PAYLOAD_W-1:0]       pay_ff, pay_in;
   logic                                  hit_ff, hit_in;
   logic [CW-1:0]                         total_ff, total_in;
   logic [CW-1:0]                         cap_ff, cap_in;
   logic [CW-1:0]                         ptr_ff, ptr_in;
   logic                                  cmp_vld_ff, cmp_vld_in;
   logic [CW-1:0]                         cmp_pos_ff, cmp_pos_in;
   logic                                  mv_vld_ff, mv_vld_in;
   logic [CW-1:0]                         mv_dst_ff, mv_dst_in;
   logic [CW-1:0]                         tail_ff, tail_in;

   logic [CW-1:0]                         last;
   logic [lrukc_pkg::KEY_W-1:0]           rd_key;
   logic [lrukc_pkg::PAYLOAD_W-1:0]       rd_pay;
   logic                                  match;
   logic [CW-1:0]                         cap_wr;

   assign last   = total_ff - CW'(1);
   assign rd_key = ram_rd_data[lrukc_pkg::ENTRY_W-1 -: lrukc_pkg::KEY_W];
   assign rd_pay = ram_rd_data[lrukc_pkg::PAYLOAD_W-1:0];
   assign match  = cmp_vld_ff && (rd_key == key_ff);

   always_comb begin
      if (int'(csr_data) > MAX_ENTRIES) begin
         cap_wr = CW'(MAX_ENTRIES);
      end else begin
         cap_wr = CW'(csr_data);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lrukc_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_data.func)
                  lrukc_pkg::FUNC_LOOKUP: begin
                     state_in = (total_ff == '0) ? lrukc_pkg::ST_DONE : lrukc_pkg::ST_SCAN;
                  end
                  lrukc_pkg::FUNC_INSERT: begin
                     if (!req_data.insert_ok) begin
                        state_in = lrukc_pkg::ST_DONE;
                     end else if (total_ff < cap_ff || total_ff == CW'(1)) begin
                        state_in = lrukc_pkg::ST_WRITE;
                     end else begin
                        state_in = lrukc_pkg::ST_SHIFT;
                     end
                  end
                  default: state_in = lrukc_pkg::ST_DONE;
               endcase
            end
         end
         lrukc_pkg::ST_SCAN: begin
            if (match) begin
               state_in = (cmp_pos_ff == last) ? lrukc_pkg::ST_WRITE : lrukc_pkg::ST_SHIFT;
            end else if (cmp_vld_ff && cmp_pos_ff == '0) begin
               state_in = lrukc_pkg::ST_DONE;
            end
         end
         lrukc_pkg::ST_SHIFT: begin
            if (ptr_ff == last) begin
               state_in = lrukc_pkg::ST_SHIFT_END;
            end
         end
         lrukc_pkg::ST_SHIFT_END: state_in = lrukc_pkg::ST_WRITE;
         lrukc_pkg::ST_WRITE:     state_in = lrukc_pkg::ST_DONE;
         lrukc_pkg::ST_DONE: begin
            if (res_free) begin
               state_in = lrukc_pkg::ST_IDLE;
            end
         end
         default: state_in = lrukc_pkg::ST_IDLE;
      endcase
   end

   // Datapath and counters
   always_comb begin
      key_in     = key_ff;
      pay_in     = pay_ff;
      hit_in     = hit_ff;
      total_in   = total_ff;
      cap_in     = cap_ff;
      ptr_in     = ptr_ff;
      cmp_vld_in = cmp_vld_ff;
      cmp_pos_in = cmp_pos_ff;
      mv_vld_in  = mv_vld_ff;
      mv_dst_in  = mv_dst_ff;
      tail_in    = tail_ff;
      case (state_ff)
         lrukc_pkg::ST_IDLE: begin
            if (req_valid) begin
               key_in     = req_data.key;
               pay_in     = req_data.payload;
               hit_in     = 1'b0;
               cmp_vld_in = 1'b0;
               mv_vld_in  = 1'b0;
               case (req_data.func)
                  lrukc_pkg::FUNC_LOOKUP: ptr_in = last;
                  lrukc_pkg::FUNC_INSERT: begin
                     if (req_data.insert_ok) begin
                        if (total_ff < cap_ff) begin
                           tail_in  = total_ff;
                           total_in = total_ff + CW'(1);
                        end else begin
                           // full: rotate out the oldest entry
                           tail_in = last;
                           ptr_in  = CW'(1);
                        end
                     end
                  end
                  lrukc_pkg::FUNC_CLEAR: total_in = '0;
                  default: ;
               endcase
            end
         end
         lrukc_pkg::ST_SCAN: begin
            cmp_vld_in = 1'b1;
            cmp_pos_in = ptr_ff;
            if (ptr_ff != '0) begin
               ptr_in = ptr_ff - CW'(1);
            end
            if (match) begin
               hit_in     = 1'b1;
               pay_in     = rd_pay;
               tail_in    = last;
               ptr_in     = cmp_pos_ff + CW'(1);
               cmp_vld_in = 1'b0;
            end
         end
         lrukc_pkg::ST_SHIFT: begin
            mv_vld_in = 1'b1;
            mv_dst_in = ptr_ff - CW'(1);
            ptr_in    = ptr_ff + CW'(1);
         end
         lrukc_pkg::ST_SHIFT_END: mv_vld_in = 1'b0;
         default: ;
      endcase
      // a zero write is dropped; lowering the limit keeps the oldest entries
      if (csr_valid && csr_data != '0) begin
         cap_in = cap_wr;
         if (total_ff > cap_wr) begin
            total_in = cap_wr;
         end
      end
   end

   // Outputs
   always_comb begin
      req_ready   = (state_ff == lrukc_pkg::ST_IDLE);
      res_valid   = (state_ff == lrukc_pkg::ST_DONE);
      ram_rd_addr = ptr_ff[IDX_W-1:0];
      ram_wr_en   = mv_vld_ff || (state_ff == lrukc_pkg::ST_WRITE);
      if (state_ff == lrukc_pkg::ST_WRITE) begin
         ram_wr_addr = tail_ff[IDX_W-1:0];
         ram_wr_data = {key_ff, pay_ff};
      end else begin
         ram_wr_addr = mv_dst_ff[IDX_W-1:0];
         ram_wr_data = ram_rd_data;
      end
      res_data.hit         = hit_ff;
      res_data.payload_out = hit_ff ? pay_ff : '0;
      res_data.fill_count  = lrukc_pkg::COUNT_W'(total_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lrukc_pkg::ST_IDLE;
         total_ff   <= '0;
         cap_ff     <= CW'(CAP_RESET);
         cmp_vld_ff <= 1'b0;
         mv_vld_ff  <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         total_ff   <= total_in;
         cap_ff     <= cap_in;
         cmp_vld_ff <= cmp_vld_in;
         mv_vld_ff  <= mv_vld_in;
         hit_ff     <= hit_in;
      end
      key_ff     <= key_in;
      pay_ff     <= pay_in;
      ptr_ff     <= ptr_in;
      cmp_pos_ff <= cmp_pos_in;
      mv_dst_ff  <= mv_dst_in;
      tail_ff    <= tail_in;
   end

endmodule
